// File: src/pss_pkg.sv
package pss_pkg;

  // Default size of the slot table.
  localparam int SLOT_COUNT_DEF = 8;

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 3;
  localparam int KIND_W  = 2;
  localparam int PHASE_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POST    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POST    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEND    = 2'd3;

  // Scanner phases.
  localparam logic [PHASE_W-1:0] PH_INIT    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CHECK   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ADVANCE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SEND    = 2'd3;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] interval_ms;
    logic [SLOT_W-1:0] slot;
  } pss_req_t;

  // Result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
    logic              ok;
  } pss_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic emit;
  } pss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nop;
  } pss_stat_t;

endpackage

// File: src/pss_ctrl.sv
module pss_ctrl
  import pss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  pss_stat_t stat,
  output pss_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // An item is taken in idle and worked on in the single execute cycle.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command outputs; the unused command code produces no result.
  assign busy       = (state == ST_EXEC);
  assign cmd.accept = start && (state == ST_IDLE);
  assign cmd.exec   = (state == ST_EXEC);
  assign cmd.emit   = (state == ST_EXEC) && !stat.nop;

  // The execute state never lasts more than one cycle.
  a_exec_one: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("execute state held for more than one cycle");

  // A result is only requested while executing.
  a_emit_exec: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> cmd.exec)
    else $error("result requested outside the execute state");

  // An accepted item is always followed by the execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst) cmd.accept |=> busy)
    else $error("accepted item not followed by the execute state");

endmodule

// File: src/pss_dp.sv
module pss_dp
  import pss_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  pss_cmd_t  ctrl,
  output pss_stat_t stat,
  input  pss_req_t  request,
  output logic      done,
  output pss_res_t  result
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = CNT_W + SLOT_W;

  // Slot table memories; the scanned slot's entry is read at each acceptance, reserved or not.
  logic [TIME_W-1:0] interval_mem [SLOT_COUNT];
  logic [TIME_W-1:0] due_mem [SLOT_COUNT];

  // Control state.
  logic [CNT_W-1:0]      slots_used;
  logic [CNT_W-1:0]      slots_used_next;
  logic [SLOT_COUNT-1:0] pending;
  logic [SLOT_COUNT-1:0] pending_next;
  logic [IDX_W-1:0]      scan_slot;
  logic [IDX_W-1:0]      scan_slot_next;
  logic [PHASE_W-1:0]    scan_phase;
  logic [PHASE_W-1:0]    scan_phase_next;
  logic [TIME_W-1:0]     now_ms;
  logic [TIME_W-1:0]     now_ms_next;

  // Latched item and registered table reads.
  pss_req_t          op;
  logic [TIME_W-1:0] ival_rd;
  logic [TIME_W-1:0] due_rd;
  logic [TIME_W-1:0] tick_now;

  // Table write port.
  logic              due_we;
  logic              ival_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [TIME_W-1:0] due_wdata;
  logic [CMP_W-1:0]  scan_inc;
  pss_res_t          res_next;

  assign stat.nop = (op.cmd == CMD_NONE);
  assign scan_inc = CMP_W'(scan_slot) + CMP_W'(1);

  // Capture the item and read the scanned slot at acceptance.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op       <= request;
      ival_rd  <= interval_mem[scan_slot];
      due_rd   <= due_mem[scan_slot];
      tick_now <= now_ms + TIME_W'(1);
    end
  end

  // Execute the latched command.
  always_comb begin
    slots_used_next = slots_used;
    pending_next    = pending;
    scan_slot_next  = scan_slot;
    scan_phase_next = scan_phase;
    now_ms_next     = now_ms;
    due_we          = 1'b0;
    ival_we         = 1'b0;
    wr_addr         = scan_slot;
    due_wdata       = tick_now + ival_rd;
    res_next        = '{kind: KIND_TICK, slot_index: '0, ok: 1'b0};
    if (ctrl.exec) begin
      case (op.cmd)
        CMD_RESERVE: begin
          if (CMP_W'(slots_used) < CMP_W'(SLOT_COUNT)) begin
            due_we    = 1'b1;
            ival_we   = 1'b1;
            wr_addr   = IDX_W'(slots_used);
            due_wdata = now_ms + op.interval_ms;
            pending_next[IDX_W'(slots_used)] = 1'b0;
            slots_used_next = slots_used + CNT_W'(1);
            res_next = '{kind: KIND_RESERVE, slot_index: SLOT_W'(slots_used), ok: 1'b1};
          end else begin
            res_next = '{kind: KIND_RESERVE, slot_index: '0, ok: 1'b0};
          end
        end
        CMD_POST: begin
          if ((CMP_W'(op.slot) < CMP_W'(slots_used)) &&
              (CMP_W'(op.slot) < CMP_W'(SLOT_COUNT))) begin
            pending_next[IDX_W'(op.slot)] = 1'b1;
            res_next = '{kind: KIND_POST, slot_index: op.slot, ok: 1'b1};
          end else begin
            res_next = '{kind: KIND_POST, slot_index: op.slot, ok: 1'b0};
          end
        end
        CMD_TICK: begin
          now_ms_next = tick_now;
          case (scan_phase)
            PH_INIT: begin
              scan_slot_next  = '0;
              scan_phase_next = PH_CHECK;
            end
            PH_CHECK: begin
              if (pending[scan_slot] && (tick_now > due_rd)) begin
                due_we          = 1'b1;
                scan_phase_next = PH_SEND;
              end else begin
                scan_phase_next = PH_ADVANCE;
              end
            end
            PH_ADVANCE: begin
              if (scan_inc < CMP_W'(slots_used)) begin
                scan_slot_next = IDX_W'(scan_inc);
              end else begin
                scan_slot_next = '0;
              end
              scan_phase_next = PH_CHECK;
            end
            default: begin
              pending_next[scan_slot] = 1'b0;
              scan_phase_next = PH_ADVANCE;
              res_next = '{kind: KIND_SEND, slot_index: SLOT_W'(scan_slot), ok: 1'b1};
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[wr_addr] <= due_wdata;
    end
    if (ival_we) begin
      interval_mem[wr_addr] <= op.interval_ms;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      pending    <= '0;
      scan_slot  <= '0;
      scan_phase <= PH_INIT;
      now_ms     <= '0;
      done       <= 1'b0;
    end else begin
      slots_used <= slots_used_next;
      pending    <= pending_next;
      scan_slot  <= scan_slot_next;
      scan_phase <= scan_phase_next;
      now_ms     <= now_ms_next;
      done       <= ctrl.emit;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result <= res_next;
    end
  end

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
      CMP_W'(slots_used) <= CMP_W'(SLOT_COUNT))
    else $error("slot fill count beyond table size");

  // The scanner stays inside the reserved part of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
      (scan_slot == '0) || (CMP_W'(scan_slot) < CMP_W'(slots_used)))
    else $error("scanner outside reserved slots");

  // A send phase always follows a check that found its slot pending.
  a_send_pending: assert property (@(posedge clk) disable iff (rst)
      (scan_phase == PH_SEND) |-> pending[scan_slot])
    else $error("send phase on a slot that is not pending");

endmodule

// File: src/periodic_slot_send_scheduler.sv
// Periodic slot send scheduler.
// Command channel: an item (request) is taken at a rising edge where start
// is high and busy is low. Commands are reserve (claim the next free slot with
// an interval), post (mark a reserved slot pending) and tick (advance the
// millisecond clock and take one scanner step). Command code 3 is ignored.
// Result channel: done is high for exactly one cycle with the result item;
// the receiver cannot stall it, so it must sample result whenever done is set.
// An accepted item sets the execute state, whose emit is registered into done.
// A new item is not taken while busy; busy is high for the execute cycle in
// which the slot table entry read at acceptance is used and written back.
// A tick that finds a pending slot past its due time reschedules it, and the
// following tick reports the send.
// Reset (rst, synchronous) empties the table, clears all pending flags, puts
// the clock at zero and the scanner at its init step.
module periodic_slot_send_scheduler
  import pss_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  pss_req_t request,
  output logic     done,
  output pss_res_t result
);

  pss_cmd_t  cmd;
  pss_stat_t stat;

  // Sequencer.
  pss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Slot table, clock and scanner.
  pss_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cmd),
    .stat    (stat),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 800;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  pss_req_t request = '0;
  logic     done;
  pss_res_t result;

  periodic_slot_send_scheduler u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Commands waiting to be driven and replies waiting to come back.
  pss_req_t cmd_backlog[$];
  pss_res_t expected_replies[$];

  // Shadow copy of the slot table, scanner and millisecond clock.
  int unsigned used_cnt;
  logic [TIME_W-1:0] slot_ivl [SLOT_COUNT_DEF];
  logic [TIME_W-1:0] slot_due_at [SLOT_COUNT_DEF];
  logic              slot_pend [SLOT_COUNT_DEF];
  logic [SLOT_W-1:0] scan_pos;
  logic [PHASE_W-1:0] scan_ph;
  logic [TIME_W-1:0] ms_now;

  // Run bookkeeping.
  logic accepted = 1'b0;
  int   issued;
  int   errors;
  int   quiet_cycles;
  int   sends_seen;
  int   replies_seen;
  int   failed_replies;
  bit   timed_out;

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the reply to one command and update the shadow state.
  function automatic pss_res_t predict_reply(pss_req_t rq);
    pss_res_t r;
    int unsigned k;
    r = '0;
    case (rq.cmd)
      CMD_RESERVE: begin
        r.kind = KIND_RESERVE;
        if (used_cnt < SLOT_COUNT_DEF) begin
          k = used_cnt;
          slot_ivl[k] = rq.interval_ms;
          slot_due_at[k] = ms_now + rq.interval_ms;
          slot_pend[k] = 1'b0;
          used_cnt = k + 1;
          r.slot_index = SLOT_W'(k);
          r.ok = 1'b1;
        end
      end
      CMD_POST: begin
        r.kind = KIND_POST;
        r.slot_index = rq.slot;
        if (int'(rq.slot) < used_cnt) begin
          slot_pend[rq.slot] = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        // A tick moves the clock first, then takes one scanner step.
        ms_now = ms_now + 1;
        r.kind = KIND_TICK;
        case (scan_ph)
          PH_INIT: begin
            scan_pos = '0;
            scan_ph = PH_CHECK;
          end
          PH_CHECK: begin
            if (slot_pend[scan_pos] && ms_now > slot_due_at[scan_pos]) begin
              slot_due_at[scan_pos] = ms_now + slot_ivl[scan_pos];
              scan_ph = PH_SEND;
            end else begin
              scan_ph = PH_ADVANCE;
            end
          end
          PH_ADVANCE: begin
            if (int'(scan_pos) + 1 < used_cnt) scan_pos = scan_pos + SLOT_W'(1);
            else scan_pos = '0;
            scan_ph = PH_CHECK;
          end
          default: begin
            slot_pend[scan_pos] = 1'b0;
            scan_ph = PH_ADVANCE;
            r.kind = KIND_SEND;
            r.slot_index = scan_pos;
            r.ok = 1'b1;
          end
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic pss_req_t make_cmd(logic [CMD_W-1:0] c, logic [TIME_W-1:0] ivl,
                                        logic [SLOT_W-1:0] s);
    pss_req_t rq;
    rq.cmd = c;
    rq.interval_ms = ivl;
    rq.slot = s;
    return rq;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: reply %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Sender: the idle rate goes from light to heavy to none over the run.
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (issued < 270) ? 21 : (issued < 540) ? 77 : 0;
    if (!rst && !(start && !accepted)) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        request <= cmd_backlog.pop_front();
        issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check replies, predict accepted items, watch for a hang.
  always @(posedge clk) begin
    pss_res_t want;
    logic hit;
    accepted <= start && !busy && !rst;
    hit = 1'b0;
    if (!rst) begin
      if (done) begin
        hit = 1'b1;
        replies_seen++;
        if (result.kind == KIND_SEND) sends_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual kind %0d slot %0d ok %0d",
                   $time, result.kind, result.slot_index, result.ok);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (!want.ok && want.kind != KIND_TICK) failed_replies++;
          report_field("kind", 32'(want.kind), 32'(result.kind));
          report_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
          report_field("ok", 32'(want.ok), 32'(result.ok));
        end
      end
      if (start && !busy) begin
        hit = 1'b1;
        if (request.cmd != CMD_NONE) expected_replies.push_back(predict_reply(request));
      end
      if (hit) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    int n;
    int pick;
    logic [TIME_W-1:0] ivl;

    used_cnt = 0;
    for (int k = 0; k < SLOT_COUNT_DEF; k++) begin
      slot_ivl[k] = '0;
      slot_due_at[k] = '0;
      slot_pend[k] = 1'b0;
    end
    scan_pos = '0;
    scan_ph = PH_INIT;
    ms_now = '0;

    // Directed: scanner on an empty table, posts to unreserved slots, the
    // ignored code, a quick send, a wrapping due time, then a full table.
    cmd_backlog.push_back(make_cmd(CMD_TICK, '0, '0));
    cmd_backlog.push_back(make_cmd(CMD_TICK, '0, '0));
    cmd_backlog.push_back(make_cmd(CMD_TICK, '1, '1));
    cmd_backlog.push_back(make_cmd(CMD_POST, '0, 3'd0));
    cmd_backlog.push_back(make_cmd(CMD_POST, '1, 3'd7));
    cmd_backlog.push_back(make_cmd(CMD_NONE, '1, 3'd7));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, '0, '0));
    cmd_backlog.push_back(make_cmd(CMD_POST, '0, 3'd0));
    for (int k = 0; k < 4; k++) cmd_backlog.push_back(make_cmd(CMD_TICK, '0, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'hFFFF_FFFF, '0));
    cmd_backlog.push_back(make_cmd(CMD_POST, '0, 3'd1));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd1, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd2, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd3, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'h8000_0000, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd5, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd7, '0));
    cmd_backlog.push_back(make_cmd(CMD_RESERVE, 32'd4, 3'd7));
    cmd_backlog.push_back(make_cmd(CMD_POST, '0, 3'd7));
    for (int k = 0; k < 3; k++) cmd_backlog.push_back(make_cmd(CMD_TICK, '0, '0));

    // Random: mostly ticks and posts so that sends keep happening, with
    // a few reserves (all refused now) and the ignored code as noise.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      ivl = ($urandom_range(3) == 0) ? $urandom : $urandom_range(6);
      if (pick < 5) begin
        cmd_backlog.push_back(make_cmd(CMD_RESERVE, ivl, SLOT_W'($urandom_range(7))));
        n++;
      end else if (pick < 30) begin
        cmd_backlog.push_back(make_cmd(CMD_POST, $urandom, SLOT_W'($urandom_range(7))));
        n++;
      end else if (pick < 98) begin
        cmd_backlog.push_back(make_cmd(CMD_TICK, $urandom, SLOT_W'($urandom_range(7))));
        n++;
      end else begin
        cmd_backlog.push_back(make_cmd(CMD_NONE, $urandom, SLOT_W'($urandom_range(7))));
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Wait for every command to go in and every reply to come back.
    while (!timed_out &&
           !(cmd_backlog.size() == 0 && !start && expected_replies.size() == 0))
      @(posedge clk);

    if (timed_out) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("Drove %0d commands and checked %0d replies: %0d sends, %0d refusals.",
               issued, replies_seen, sends_seen, failed_replies);
      $display("Sender idling went light, heavy, then off; %0d mismatches.", errors);
      if (errors == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule
